FILE: hdl/lipc_pkg.sv
// Shared types, constants and helper functions for the lossless image predictor codec.
// No dependencies; every other file in this folder imports this package.
package lipc_pkg;

  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned WidthW   = 11;
  localparam int unsigned HeightW  = 16;
  localparam int unsigned PixW     = 8;
  localparam int unsigned SampleW  = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Reciprocal of three for sums below 768: floor(x * 683 / 2048) == floor(x / 3).
  localparam int unsigned Recip3      = 683;
  localparam int unsigned Recip3Shift = 11;

  localparam logic [CfgIdxW-1:0] RegMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd2;

  localparam logic [WidthW-1:0]  WidthReset  = 11'd1024;
  localparam logic [HeightW-1:0] HeightReset = 16'd1024;

  typedef struct packed {
    logic [ColW-1:0]    col;
    logic [HeightW-1:0] row;
  } pos_t;

  typedef struct packed {
    logic [ColW-1:0] rd_addr_a;
    logic [ColW-1:0] rd_addr_b;
    logic            wr_en;
    logic [ColW-1:0] wr_addr;
    logic [PixW-1:0] wr_data;
  } store_req_t;

  typedef struct packed {
    logic signed [SampleW-1:0] result;
    logic                      end_of_row;
    logic                      end_of_image;
  } result_t;

  function automatic logic [WidthW-1:0] eff_width(logic [WidthW-1:0] w);
    logic [WidthW-1:0] r;
    r = w;
    if (w == '0) begin
      r = WidthW'(1);
    end else if (w > WidthW'(MaxWidth)) begin
      r = WidthW'(MaxWidth);
    end
    return r;
  endfunction

  function automatic logic [HeightW-1:0] eff_height(logic [HeightW-1:0] h);
    return (h == '0) ? HeightW'(1) : h;
  endfunction

  // Out-of-range position from a register change wraps to the next row or to row 0.
  function automatic pos_t wrap_pos(pos_t p, logic [WidthW-1:0] w, logic [HeightW-1:0] h);
    pos_t            r;
    logic [HeightW:0] row_t;
    r     = p;
    row_t = {1'b0, p.row};
    if ({1'b0, p.col} >= w) begin
      r.col = '0;
      row_t = {1'b0, p.row} + (HeightW+1)'(1);
    end
    if (row_t >= {1'b0, h}) begin
      r.row = '0;
    end else begin
      r.row = row_t[HeightW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/lipc_line_store.sv
// Previous-row line store: one write port and two registered read ports.
// A read of the entry written at the same edge returns the new data. Uses lipc_pkg.
module lipc_line_store
  import lipc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  store_req_t      req_i,
  output logic [PixW-1:0] rd_data_a_o,
  output logic [PixW-1:0] rd_data_b_o
);

  logic [PixW-1:0] mem [MaxWidth];
  logic [PixW-1:0] mem_a_q, mem_b_q, fwd_data_q;
  logic            hit_a_q, hit_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    mem_a_q    <= mem[req_i.rd_addr_a];
    mem_b_q    <= mem[req_i.rd_addr_b];
    fwd_data_q <= req_i.wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
    end else begin
      hit_a_q <= req_i.wr_en && (req_i.wr_addr == req_i.rd_addr_a);
      hit_b_q <= req_i.wr_en && (req_i.wr_addr == req_i.rd_addr_b);
    end
  end

  assign rd_data_a_o = hit_a_q ? fwd_data_q : mem_a_q;
  assign rd_data_b_o = hit_b_q ? fwd_data_q : mem_b_q;

endmodule

FILE: hdl/lipc_skid.sv
// Two-entry output buffer: an output register plus a skid register.
// Input ready depends only on local state. Uses lipc_pkg.
module lipc_skid
  import lipc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  result_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  result_t out_data_q, out_data_d, skid_data_q, skid_data_d;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_valid_q && out_ready_i) begin
      if (skid_valid_q) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else if (in_valid_i) begin
        out_data_d = in_data_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (in_valid_i && !skid_valid_q) begin
      if (!out_valid_q) begin
        out_data_d  = in_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = in_data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

endmodule

FILE: hdl/lossless_image_predictor_codec.sv
// Top level of the lossless image predictor codec (DPCM encode and decode).
// Uses lipc_pkg, lipc_line_store and lipc_skid.
//
// The codec takes one request per clock and delivers its result through a registered output,
// sustaining one pixel per cycle as long as results are taken; a two-entry output buffer keeps
// the input open while one result waits. The rate is set by the line store, a 1024 x 8 memory
// with two read ports and one write port that serves the pixel above and the one above-right
// for the current position each cycle, while the previous pixel is written back in the same
// cycle and forwarded. The line store needs no clearing pass after reset.
module lossless_image_predictor_codec
  import lipc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SampleW-1:0]  sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SampleW-1:0]  result_o,
  output logic                       end_of_row_o,
  output logic                       end_of_image_o
);

  logic                mode_q, mode_d;
  logic [WidthW-1:0]   width_q, width_d, w_cur;
  logic [HeightW-1:0]  height_q, height_d, h_cur;
  pos_t                pos_q, pos_d, cur, nxt;
  logic [PixW-1:0]     left_q, upleft_q;
  logic [PixW-1:0]     up, upright, pred, pix;
  logic [PixW+1:0]     sum4, sum3;
  logic [2*(PixW+2)-1:0] prod3;
  logic                accept, eor, eoi;
  store_req_t          store_req;
  result_t             res;
  result_t             out_data;

  assign accept = in_valid_i && in_ready_o;
  assign w_cur  = eff_width(width_q);
  assign h_cur  = eff_height(height_q);
  assign cur    = wrap_pos(pos_q, w_cur, h_cur);

  always_comb begin
    mode_d   = mode_q;
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        RegMode:   mode_d   = cfg_data_i[0];
        RegWidth:  width_d  = cfg_data_i[WidthW-1:0];
        RegHeight: height_d = cfg_data_i[HeightW-1:0];
        default:   ;
      endcase
    end
  end

  assign sum4  = (PixW+2)'(left_q) + (PixW+2)'(upleft_q) + (PixW+2)'(up) + (PixW+2)'(upright);
  assign sum3  = (PixW+2)'(left_q) + (PixW+2)'(upleft_q) + (PixW+2)'(up);
  assign prod3 = (2*(PixW+2))'(sum3) * (2*(PixW+2))'(Recip3);

  always_comb begin
    if (cur.row == '0) begin
      pred = (cur.col == '0) ? '0 : left_q;
    end else if (cur.col == '0) begin
      pred = up;
    end else if (({1'b0, cur.col} + WidthW'(1)) < w_cur) begin
      pred = sum4[PixW+1:2];
    end else begin
      pred = prod3[Recip3Shift+PixW-1:Recip3Shift];
    end
  end

  always_comb begin
    if (!mode_q) begin
      pix        = sample_i[PixW-1:0];
      res.result = $signed({1'b0, pix} - {1'b0, pred});
    end else begin
      pix        = pred + sample_i[PixW-1:0];
      res.result = $signed({1'b0, pix});
    end
    eor              = ({1'b0, cur.col} == (w_cur - WidthW'(1)));
    eoi              = eor && (cur.row == (h_cur - HeightW'(1)));
    res.end_of_row   = eor;
    res.end_of_image = eoi;
  end

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (eor) begin
        pos_d.col = '0;
        pos_d.row = eoi ? '0 : cur.row + HeightW'(1);
      end else begin
        pos_d.col = cur.col + ColW'(1);
        pos_d.row = cur.row;
      end
    end
  end

  // Read addresses follow the position the next request will see.
  assign nxt = wrap_pos(pos_d, eff_width(width_d), eff_height(height_d));

  assign store_req.rd_addr_a = nxt.col;
  assign store_req.rd_addr_b = nxt.col + ColW'(1);
  assign store_req.wr_en     = accept;
  assign store_req.wr_addr   = cur.col;
  assign store_req.wr_data   = pix;

  lipc_line_store u_line_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (store_req),
    .rd_data_a_o (up),
    .rd_data_b_o (upright)
  );

  lipc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign result_o       = out_data.result;
  assign end_of_row_o   = out_data.end_of_row;
  assign end_of_image_o = out_data.end_of_image;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      width_q  <= WidthReset;
      height_q <= HeightReset;
      pos_q    <= '0;
      left_q   <= '0;
      upleft_q <= '0;
    end else begin
      mode_q   <= mode_d;
      width_q  <= width_d;
      height_q <= height_d;
      pos_q    <= pos_d;
      if (accept) begin
        left_q   <= pix;
        upleft_q <= up;
      end
    end
  end

  a_eoi_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_image_o |-> end_of_row_o)
    else $error("End of image flagged without end of row.");

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && eor |=> pos_q.col == '0)
    else $error("Column did not return to zero after the last pixel of a row.");

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !eor |=> pos_q.col == $past(cur.col) + ColW'(1))
    else $error("Column did not advance by one.");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("Input blocked while no result is pending.");

endmodule

FILE: tb/sv/tb_lossless_image_predictor_codec.sv
// Self-checking testbench for lossless_image_predictor_codec: directed table, then random images.
// A local DPCM predictor expects a result per accepted request; typed table rows give their own.
// Depends on lipc_pkg and the codec RTL; it needs no other file.
module tb_lossless_image_predictor_codec;
  timeunit 1ns;
  timeprecision 1ps;

  import lipc_pkg::*;

  localparam bit          ModeEncode  = 1'b0;
  localparam bit          ModeDecode  = 1'b1;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned RandomItems = 150;
  localparam int unsigned MaxReports  = 10;

  typedef enum logic {RowSample, RowReg} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    logic [SampleW-1:0]   smp;
    logic                 typed;
    result_t              want;
  } step_row_t;

  localparam int unsigned DirRows = 38;
  localparam step_row_t Directed [DirRows] = '{
    '{RowSample, '0, '0, 9'h0AB, 1'b1, '{9'h0AB, 1'b0, 1'b0}},
    '{RowSample, '0, '0, 9'h1FF, 1'b0, '0},
    '{RowReg, RegWidth, 16'd3, '0, 1'b0, '0},
    '{RowSample, '0, '0, 9'h000, 1'b1, '{9'h101, 1'b1, 1'b0}},
    '{RowReg, RegHeight, 16'd2, '0, 1'b0, '0},
    '{RowSample, '0, '0, 9'h080, 1'b0, '0},
    '{RowSample, '0, '0, 9'h17F, 1'b0, '0},
    '{RowSample, '0, '0, 9'h0FF, 1'b0, '0},
    '{RowReg, RegMode, 16'hFFFF, '0, 1'b0, '0},
    '{RowReg, RegWidth, 16'hF801, '0, 1'b0, '0},
    '{RowReg, RegHeight, 16'h0000, '0, 1'b0, '0},
    '{RowSample, '0, '0, 9'h1FF, 1'b1, '{9'h0FF, 1'b1, 1'b1}},
    '{RowSample, '0, '0, 9'h101, 1'b1, '{9'h001, 1'b1, 1'b1}},
    '{RowReg, RegHeight, 16'd3, '0, 1'b0, '0},
    '{RowSample, '0, '0, 9'h0C8, 1'b0, '0},
    '{RowSample, '0, '0, 9'h064, 1'b0, '0},
    '{RowSample, '0, '0, 9'h1F0, 1'b0, '0},
    '{RowReg, RegWidth, 16'h0000, '0, 1'b0, '0},
    '{RowReg, RegHeight, 16'h0000, '0, 1'b0, '0},
    '{RowSample, '0, '0, 9'h000, 1'b1, '{9'h000, 1'b1, 1'b1}},
    '{RowReg, RegMode, 16'h0000, '0, 1'b0, '0},
    '{RowReg, RegWidth, 16'h07FF, '0, 1'b0, '0},
    '{RowReg, RegHeight, 16'd1, '0, 1'b0, '0},
    '{RowSample, '0, '0, 9'h0FF, 1'b1, '{9'h0FF, 1'b0, 1'b0}},
    '{RowSample, '0, '0, 9'h100, 1'b1, '{9'h101, 1'b0, 1'b0}},
    '{RowReg, RegWidth, 16'd4, '0, 1'b0, '0},
    '{RowSample, '0, '0, 9'h055, 1'b0, '0},
    '{RowSample, '0, '0, 9'h1AA, 1'b0, '0},
    '{RowReg, RegHeight, 16'd3, '0, 1'b0, '0},
    '{RowSample, '0, '0, 9'h010, 1'b0, '0},
    '{RowSample, '0, '0, 9'h020, 1'b0, '0},
    '{RowSample, '0, '0, 9'h030, 1'b0, '0},
    '{RowSample, '0, '0, 9'h040, 1'b0, '0},
    '{RowSample, '0, '0, 9'h0F0, 1'b0, '0},
    '{RowSample, '0, '0, 9'h00F, 1'b0, '0},
    '{RowReg, RegWidth, 16'd2, '0, 1'b0, '0},
    '{RowSample, '0, '0, 9'h1E0, 1'b0, '0},
    '{RowSample, '0, '0, 9'h07E, 1'b0, '0}
  };

  logic                      clk_i;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]        cfg_index_i = RegMode;
  logic [CfgDataW-1:0]       cfg_data_i  = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] sample_i    = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [SampleW-1:0] result_o;
  logic                      end_of_row_o;
  logic                      end_of_image_o;

  lossless_image_predictor_codec i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_o       (result_o),
    .end_of_row_o   (end_of_row_o),
    .end_of_image_o (end_of_image_o)
  );

  result_t          predicted_results [$];
  int unsigned      mismatch_count = 0;
  int unsigned      items_sent     = 0;
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_idle_pct  = 0;
  int unsigned      hold_orders    = 0;

  bit [PixW-1:0]    line_px  [MaxWidth];
  bit               line_set [MaxWidth];
  int unsigned      left_px, upleft_px, col_pos, row_pos;
  bit               cfg_mode;
  bit [WidthW-1:0]  cfg_width;
  bit [HeightW-1:0] cfg_height;

  function automatic int unsigned clamp_width(bit [WidthW-1:0] w);
    if (w == 0) return 1;
    if (w > MaxWidth) return MaxWidth;
    return 32'(w);
  endfunction

  function automatic int unsigned clamp_height(bit [HeightW-1:0] h);
    return (h == 0) ? 1 : 32'(h);
  endfunction

  function automatic void wrapped_pos(input bit [WidthW-1:0] w, input bit [HeightW-1:0] h,
                                      output int unsigned c, output int unsigned r);
    c = col_pos;
    r = row_pos;
    if (c >= clamp_width(w)) begin
      c = 0;
      r++;
    end
    if (r >= clamp_height(h)) r = 0;
  endfunction

  // A setting is safe when no row above the current position reads an unwritten column.
  function automatic bit store_ready(bit [WidthW-1:0] w, bit [HeightW-1:0] h);
    int unsigned c, r, lim;
    wrapped_pos(w, h, c, r);
    lim = (r == 0) ? c : clamp_width(w);
    for (int k = 0; k < lim; k++) begin
      if (!line_set[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned pixels_left();
    int unsigned c, r;
    wrapped_pos(cfg_width, cfg_height, c, r);
    return (clamp_height(cfg_height) - r) * clamp_width(cfg_width) - c;
  endfunction

  function automatic result_t predict_pixel(bit [SampleW-1:0] smp);
    int unsigned w, h, c, r, up, pred, pix;
    result_t     res;
    w = clamp_width(cfg_width);
    h = clamp_height(cfg_height);
    wrapped_pos(cfg_width, cfg_height, c, r);
    col_pos = c;
    row_pos = r;
    up = 32'(line_px[col_pos]);
    if (row_pos == 0) begin
      pred = (col_pos == 0) ? 0 : left_px;
    end else if (col_pos == 0) begin
      pred = up;
    end else if (col_pos + 1 < w) begin
      pred = (left_px + upleft_px + up + 32'(line_px[col_pos + 1])) / 4;
    end else begin
      pred = (left_px + upleft_px + up) / 3;
    end
    if (cfg_mode == ModeEncode) begin
      pix = 32'(smp[PixW-1:0]);
      res.result = SampleW'(pix - pred);
    end else begin
      pix = (pred + 32'(smp)) & 32'hFF;
      res.result = SampleW'(pix);
    end
    res.end_of_row   = (col_pos == w - 1);
    res.end_of_image = res.end_of_row && (row_pos == h - 1);
    upleft_px         = up;
    line_px[col_pos]  = PixW'(pix);
    line_set[col_pos] = 1'b1;
    left_px           = pix;
    if (res.end_of_row) begin
      col_pos = 0;
      row_pos = res.end_of_image ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return res;
  endfunction

  function automatic bit [SampleW-1:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      case ($urandom_range(3))
        0: return 9'h000;
        1: return 9'h0FF;
        2: return 9'h100;
        default: return 9'h1FF;
      endcase
    end
    if (pick < 4 && cfg_mode == ModeDecode) return SampleW'($urandom_range(16)) - 9'd8;
    return SampleW'($urandom);
  endfunction

  task automatic send_sample(input bit [SampleW-1:0] smp, input bit use_typed,
                             input result_t typed_res);
    result_t res;
    cfg_we_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= smp;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    res = predict_pixel(smp);
    predicted_results.push_back(use_typed ? typed_res : res);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    cfg_we_i   <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      RegMode:   cfg_mode   = val[0];
      RegWidth:  cfg_width  = val[WidthW-1:0];
      RegHeight: cfg_height = val[HeightW-1:0];
      default: ;
    endcase
  endtask

  task automatic random_segment(input bit with_hold);
    int unsigned         pick, n;
    bit                  do_w, do_h, at_start;
    logic [CfgDataW-1:0] w_v, h_v;
    drain();
    at_start = (col_pos == 0 && row_pos == 0);
    pick = $urandom_range(99);
    if (pick < 55) w_v = CfgDataW'($urandom_range(6, 1));
    else if (pick < 85) w_v = CfgDataW'($urandom_range(40, 7));
    else if (pick < 92) w_v = '0;
    else w_v = CfgDataW'($urandom_range(3, 1));
    if ($urandom_range(3) == 0) w_v[CfgDataW-1:WidthW] = (CfgDataW-WidthW)'($urandom);
    pick = $urandom_range(99);
    if (pick < 60) h_v = CfgDataW'($urandom_range(5, 1));
    else if (pick < 85) h_v = CfgDataW'($urandom_range(12, 6));
    else if (pick < 93) h_v = '0;
    else h_v = 16'hFFFF;
    do_w = at_start ? ($urandom_range(3) != 0) : ($urandom_range(3) == 0);
    do_h = at_start ? ($urandom_range(3) != 0) : ($urandom_range(4) == 0);
    if (!store_ready(do_w ? w_v[WidthW-1:0] : cfg_width, do_h ? h_v : cfg_height)) do_w = 1'b0;
    if (!store_ready(do_w ? w_v[WidthW-1:0] : cfg_width, do_h ? h_v : cfg_height)) do_h = 1'b0;
    if ($urandom_range(2) == 0) write_reg(RegMode, CfgDataW'($urandom));
    if (do_w) write_reg(RegWidth, w_v);
    if (do_h) write_reg(RegHeight, h_v);
    n = pixels_left();
    if (n > 300 || $urandom_range(3) == 0) n = $urandom_range((n < 40) ? n : 40, 1);
    if (with_hold && n < 24) n = 24;
    if (with_hold) hold_orders++;
    repeat (n) send_sample(random_sample(), 1'b0, '0);
  endtask

  task automatic wide_row();
    drain();
    if (!store_ready(cfg_width, HeightW'(1))) return;
    write_reg(RegHeight, CfgDataW'(1));
    repeat (pixels_left()) send_sample(random_sample(), 1'b0, '0);
    drain();
    write_reg(RegWidth, CfgDataW'(MaxWidth));
    repeat (MaxWidth) send_sample(random_sample(), 1'b0, '0);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(2_000_000);
    $display("lossless_image_predictor_codec regression: fail");
    $finish;
  end

  initial begin
    int unsigned holds_done;
    int unsigned hold_left;
    holds_done = 0;
    hold_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (holds_done != hold_orders) begin
        holds_done  = hold_orders;
        hold_left   = HoldCycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (predicted_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("result %0d eor %b eoi %b with no request pending",
                   result_o, end_of_row_o, end_of_image_o);
        end
      end else begin
        want = predicted_results.pop_front();
        if (result_o !== want.result || end_of_row_o !== want.end_of_row ||
            end_of_image_o !== want.end_of_image) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("mismatch: expected %0d eor %b eoi %b, got %0d eor %b eoi %b",
                     want.result, want.end_of_row, want.end_of_image,
                     result_o, end_of_row_o, end_of_image_o);
          end
        end
      end
    end
  end

  initial begin
    int unsigned phase_goal;
    cfg_mode   = ModeEncode;
    cfg_width  = WidthW'(1024);
    cfg_height = HeightW'(1024);
    left_px    = 0;
    upleft_px  = 0;
    col_pos    = 0;
    row_pos    = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 31;
    recv_idle_pct = 77;
    foreach (Directed[i]) begin
      if (Directed[i].kind == RowReg) begin
        drain();
        write_reg(Directed[i].idx, Directed[i].data);
      end else begin
        send_sample(Directed[i].smp, Directed[i].typed, Directed[i].want);
      end
    end

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 31 : (p == 1) ? 77 : 0;
      recv_idle_pct = (p == 0) ? 77 : (p == 1) ? 31 : 0;
      if (p == 2) wide_row();
      phase_goal = items_sent + RandomItems / 3;
      random_segment(1'b1);
      while (items_sent < phase_goal) random_segment(1'b0);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("lossless_image_predictor_codec regression: pass");
    end else begin
      $display("lossless_image_predictor_codec regression: fail");
    end
    $finish;
  end

endmodule
